// ----- design/gm3_pkg.sv -----
// Shared types and constants of the 3D geometric median block.
// Used through scoped names by every module of the block but gm3_ram; depends on nothing.
package gm3_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int COORD_W    = 32;
    localparam int PT_W       = 3 * COORD_W;
    localparam int SUM_W      = COORD_W + ADDR_W;
    localparam int IT_W       = 8;
    localparam int EPS_W      = 32;
    localparam int THR_W      = 16;
    localparam int THR_SHIFT  = 12;
    localparam int W_W        = 44;
    localparam int WS_W       = W_W + ADDR_W;
    localparam int ACC_W      = 86;
    localparam int COST_W     = 64;
    localparam int ROOT_W     = 32;
    localparam int DIST_W     = ROOT_W + 1;
    localparam int SQR_W      = ROOT_W + 2;
    localparam int STEP_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_W      = PT_W + IT_W;
    localparam int REASON_W   = 2;

    localparam logic [CNT_W-1:0]  FULL_CNT       = CNT_W'(MAX_POINTS);
    localparam logic [STEP_W-1:0] STEP_LAST_SHORT = STEP_W'(COORD_W - 1);
    localparam logic [STEP_W-1:0] STEP_LAST_LONG  = STEP_W'(W_W - 1);
    localparam logic [4:0]        SQRT_LAST       = 5'd31;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_THR = 2'd2;

    localparam logic [IT_W-1:0]  RST_MAX_ITER = 8'd10;
    localparam logic [EPS_W-1:0] RST_EPS      = 32'd66;
    localparam logic [THR_W-1:0] RST_ZERO_THR = 16'd1;

    // stop reasons
    localparam logic [REASON_W-1:0] STOP_LIMIT = 2'd0;
    localparam logic [REASON_W-1:0] STOP_CONV  = 2'd1;
    localparam logic [REASON_W-1:0] STOP_WSUM  = 2'd2;

    typedef enum logic [4:0] {
        S_LOAD,
        S_MEAN_START,
        S_MEAN_WAIT,
        S_ITER_CHECK,
        S_PT_READ,
        S_PT_LATCH,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_START,
        S_SQRT_WAIT,
        S_PT_CHECK,
        S_W_WAIT,
        S_PW_LO,
        S_PW_MID,
        S_PW_HI,
        S_NEXT_PT,
        S_PASS_END,
        S_EST_START,
        S_EST_WAIT,
        S_ITER_END,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_WEIGHT,
        DIV_EST
    } div_sel_t;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_WLO,
        MUL_WHI
    } mul_sel_t;

    typedef struct packed {
        logic     in_take;
        logic     solve_init;
        logic     set_clear;
        logic     div_start;
        div_sel_t div_sel;
        logic     est_load;
        logic     ax_clr;
        logic     ax_inc;
        logic     pass_init;
        logic     pt_latch;
        mul_sel_t mul_sel;
        logic     q_acc;
        logic     sq_start;
        logic     w_load;
        logic     acc_lo;
        logic     acc_hi;
        logic     idx_inc;
        logic     stop_wsum;
        logic     iter_done;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic sq_done;
        logic div_done;
        logic ax_last;
        logic idx_last;
        logic iter_limit;
        logic pt_skip;
        logic wsum_low;
        logic converged;
        logic out_free;
    } stat_t;

endpackage

// ----- design/gm3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/gm3_div.sv -----
// Restoring divider, one quotient bit per cycle, 32 or 44 steps.
// Depends on gm3_pkg for widths.
module gm3_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        long_div,
    input  logic [gm3_pkg::ACC_W-1:0]   num,
    input  logic [gm3_pkg::WS_W-1:0]    den,
    output logic [gm3_pkg::W_W-1:0]     quo,
    output logic                        done
);

    localparam int WS_W   = gm3_pkg::WS_W;
    localparam int W_W    = gm3_pkg::W_W;
    localparam int STEP_W = gm3_pkg::STEP_W;

    logic [WS_W-1:0]   rem_reg, rem_next;
    logic [WS_W-1:0]   den_reg;
    logic [W_W-1:0]    low_reg, quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              long_reg, busy_reg, done_reg;
    logic [WS_W:0]     trial, diff;
    logic              ge, last_step;

    always_comb begin
        trial     = {rem_reg, low_reg[W_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = trial >= {1'b0, den_reg};
        rem_next  = ge ? diff[WS_W-1:0] : trial[WS_W-1:0];
        last_step = cnt_reg == (long_reg ? gm3_pkg::STEP_LAST_LONG
                                         : gm3_pkg::STEP_LAST_SHORT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last_step;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            long_reg <= long_div;
            den_reg  <= den;
            quo_reg  <= '0;
            if (long_div) begin
                rem_reg <= WS_W'(num[gm3_pkg::ACC_W-1:W_W]);
                low_reg <= num[W_W-1:0];
            end else begin
                rem_reg <= num[gm3_pkg::ACC_W-1:gm3_pkg::COORD_W];
                low_reg <= {num[gm3_pkg::COORD_W-1:0], (W_W - gm3_pkg::COORD_W)'(0)};
            end
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[W_W-2:0], 1'b0};
            quo_reg <= {quo_reg[W_W-2:0], ge};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ----- design/gm3_dpath.sv -----
// Datapath: point store, sums, shared multiplier, square root, accumulators,
// configuration registers and output register. Depends on gm3_pkg, gm3_ram, gm3_div.
module gm3_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  gm3_pkg::cmd_t                    cmd,
    output gm3_pkg::stat_t                   stat,
    input  logic [gm3_pkg::PT_W-1:0]         s_tdata,
    input  logic                             cfg_valid,
    input  logic [gm3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gm3_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [gm3_pkg::OUT_W-1:0]        m_tdata,
    output logic [gm3_pkg::REASON_W-1:0]     m_tuser
);

    localparam int ADDR_W  = gm3_pkg::ADDR_W;
    localparam int CNT_W   = gm3_pkg::CNT_W;
    localparam int COORD_W = gm3_pkg::COORD_W;
    localparam int SUM_W   = gm3_pkg::SUM_W;
    localparam int IT_W    = gm3_pkg::IT_W;
    localparam int W_W     = gm3_pkg::W_W;
    localparam int WS_W    = gm3_pkg::WS_W;
    localparam int ACC_W   = gm3_pkg::ACC_W;
    localparam int COST_W  = gm3_pkg::COST_W;
    localparam int ROOT_W  = gm3_pkg::ROOT_W;
    localparam int DIST_W  = gm3_pkg::DIST_W;
    localparam int SQR_W   = gm3_pkg::SQR_W;

    // configuration
    logic [IT_W-1:0]           max_iter_reg;
    logic [gm3_pkg::EPS_W-1:0] eps_reg;
    logic [gm3_pkg::THR_W-1:0] zthr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= gm3_pkg::RST_MAX_ITER;
            eps_reg      <= gm3_pkg::RST_EPS;
            zthr_reg     <= gm3_pkg::RST_ZERO_THR;
        end else if (cfg_valid) begin
            case (cfg_index)
                gm3_pkg::REG_MAX_ITER: max_iter_reg <= cfg_data[IT_W-1:0];
                gm3_pkg::REG_EPS:      eps_reg      <= cfg_data;
                gm3_pkg::REG_ZERO_THR: zthr_reg     <= cfg_data[gm3_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // point loading
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   sum_reg [3];
    logic [CNT_W-1:0]   idx_reg;
    logic               wr_en;
    logic [gm3_pkg::PT_W-1:0] ram_rdata;

    assign wr_en = cmd.in_take && (cnt_reg < gm3_pkg::FULL_CNT);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.set_clear) begin
            cnt_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                sum_reg[k] <= '0;
            end
        end else if (wr_en) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            for (int k = 0; k < 3; k++) begin
                sum_reg[k] <= sum_reg[k] +
                    {{(SUM_W-COORD_W){s_tdata[k*COORD_W+COORD_W-1]}},
                     s_tdata[k*COORD_W +: COORD_W]};
            end
        end
    end

    gm3_ram #(
        .WIDTH (gm3_pkg::PT_W),
        .DEPTH (gm3_pkg::MAX_POINTS)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // iteration state
    logic [1:0]             ax_reg;
    logic [COORD_W-1:0]     est_reg [3];
    logic [COORD_W-1:0]     pt_reg  [3];
    logic [2*COORD_W-1:0]   prod_reg;
    logic [COST_W-1:0]      q_reg;
    logic [W_W-1:0]         w_reg;
    logic [WS_W-1:0]        wsum_reg;
    logic [COST_W-1:0]      cost_reg, prev_reg;
    logic [ACC_W-1:0]       acc_reg [3];
    logic [IT_W-1:0]        it_reg;
    logic [gm3_pkg::REASON_W-1:0] reason_reg;

    // square root unit
    logic [COST_W-1:0]  sq_val_reg;
    logic [SQR_W-1:0]   sq_rem_reg;
    logic [ROOT_W-1:0]  sq_root_reg;
    logic [4:0]         sq_cnt_reg;
    logic               sq_busy_reg, sq_done_reg;
    logic [SQR_W+1:0]   sq_r2, sq_trial, sq_diff;
    logic               sq_ge;

    // divider hookup
    logic                 div_long;
    logic [ACC_W-1:0]     div_num;
    logic [WS_W-1:0]      div_den;
    logic [W_W-1:0]       div_quo;
    logic                 div_done;

    // combinational helpers
    logic [COORD_W:0]     dif;
    logic [COORD_W-1:0]   a_mag, p_mag, mul_a, mul_b, est_val, q32;
    logic [DIST_W-1:0]    dist_val;
    logic [SUM_W-1:0]     sum_mag;
    logic [ACC_W-1:0]     acc_mag, lo_term, hi_term;
    logic                 quo_neg, pt_neg;
    logic [COST_W-1:0]    term, cost_diff;
    logic [COST_W:0]      cost_sum;

    always_comb begin
        pt_neg  = pt_reg[ax_reg][COORD_W-1];
        dif     = {pt_reg[ax_reg][COORD_W-1], pt_reg[ax_reg]} -
                  {est_reg[ax_reg][COORD_W-1], est_reg[ax_reg]};
        a_mag   = dif[COORD_W] ? COORD_W'((COORD_W+1)'(0) - dif) : dif[COORD_W-1:0];
        p_mag   = pt_neg ? COORD_W'(0) - pt_reg[ax_reg] : pt_reg[ax_reg];

        case (cmd.mul_sel)
            gm3_pkg::MUL_SQ: begin
                mul_a = a_mag;
                mul_b = a_mag;
            end
            gm3_pkg::MUL_WLO: begin
                mul_a = p_mag;
                mul_b = w_reg[COORD_W-1:0];
            end
            gm3_pkg::MUL_WHI: begin
                mul_a = p_mag;
                mul_b = COORD_W'(w_reg[W_W-1:COORD_W]);
            end
            default: begin
                mul_a = a_mag;
                mul_b = a_mag;
            end
        endcase

        sq_r2    = {sq_rem_reg, sq_val_reg[COST_W-1:COST_W-2]};
        sq_trial = {2'b00, sq_root_reg, 2'b01};
        sq_diff  = sq_r2 - sq_trial;
        sq_ge    = sq_r2 >= sq_trial;
        dist_val = {sq_root_reg, 1'b0};

        sum_mag = sum_reg[ax_reg][SUM_W-1] ? SUM_W'(0) - sum_reg[ax_reg] : sum_reg[ax_reg];
        acc_mag = acc_reg[ax_reg][ACC_W-1] ? ACC_W'(0) - acc_reg[ax_reg] : acc_reg[ax_reg];

        case (cmd.div_sel)
            gm3_pkg::DIV_MEAN: begin
                div_long = 1'b0;
                div_num  = ACC_W'(sum_mag);
                div_den  = WS_W'(cnt_reg);
                quo_neg  = sum_reg[ax_reg][SUM_W-1];
            end
            gm3_pkg::DIV_WEIGHT: begin
                div_long = 1'b1;
                div_num  = ACC_W'(1) << W_W;
                div_den  = WS_W'(dist_val);
                quo_neg  = 1'b0;
            end
            gm3_pkg::DIV_EST: begin
                div_long = 1'b0;
                div_num  = acc_mag;
                div_den  = wsum_reg;
                quo_neg  = acc_reg[ax_reg][ACC_W-1];
            end
            default: begin
                div_long = 1'b0;
                div_num  = acc_mag;
                div_den  = wsum_reg;
                quo_neg  = acc_reg[ax_reg][ACC_W-1];
            end
        endcase
        q32     = div_quo[COORD_W-1:0];
        est_val = quo_neg ? COORD_W'(0) - q32 : q32;

        // cost term saturates at all ones
        term      = (q_reg[COST_W-1:COST_W-2] != 2'b00) ? '1 : {q_reg[COST_W-3:0], 2'b00};
        cost_sum  = {1'b0, cost_reg} + {1'b0, term};
        cost_diff = (cost_reg > prev_reg) ? cost_reg - prev_reg : prev_reg - cost_reg;

        lo_term = ACC_W'(prod_reg);
        hi_term = ACC_W'(prod_reg) << COORD_W;
    end

    gm3_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .long_div (div_long),
        .num      (div_num),
        .den      (div_den),
        .quo      (div_quo),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end else begin
            sq_done_reg <= sq_busy_reg && (sq_cnt_reg == gm3_pkg::SQRT_LAST);
            if (cmd.sq_start) begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= '0;
            end else if (sq_busy_reg) begin
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == gm3_pkg::SQRT_LAST) begin
                    sq_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sq_start) begin
            sq_val_reg  <= q_reg;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end else if (sq_busy_reg) begin
            sq_val_reg  <= {sq_val_reg[COST_W-3:0], 2'b00};
            sq_rem_reg  <= sq_ge ? sq_diff[SQR_W-1:0] : sq_r2[SQR_W-1:0];
            sq_root_reg <= {sq_root_reg[ROOT_W-2:0], sq_ge};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        if (cmd.ax_clr) begin
            ax_reg <= '0;
        end else if (cmd.ax_inc) begin
            ax_reg <= ax_reg + 2'd1;
        end

        if (cmd.est_load) begin
            est_reg[ax_reg] <= est_val;
        end

        if (cmd.pt_latch) begin
            for (int k = 0; k < 3; k++) begin
                pt_reg[k] <= ram_rdata[k*COORD_W +: COORD_W];
            end
            q_reg <= '0;
        end else if (cmd.q_acc) begin
            q_reg <= q_reg + {2'b00, prod_reg[2*COORD_W-1:2]};
        end

        if (cmd.pass_init) begin
            wsum_reg <= '0;
            cost_reg <= '0;
            idx_reg  <= '0;
            for (int k = 0; k < 3; k++) begin
                acc_reg[k] <= '0;
            end
        end else begin
            if (cmd.idx_inc) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.w_load) begin
                w_reg    <= div_quo;
                wsum_reg <= wsum_reg + WS_W'(div_quo);
                cost_reg <= cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
            end
            if (cmd.acc_lo) begin
                acc_reg[ax_reg] <= pt_neg ? acc_reg[ax_reg] - lo_term
                                          : acc_reg[ax_reg] + lo_term;
            end else if (cmd.acc_hi) begin
                acc_reg[ax_reg] <= pt_neg ? acc_reg[ax_reg] - hi_term
                                          : acc_reg[ax_reg] + hi_term;
            end
        end

        if (cmd.solve_init) begin
            it_reg     <= '0;
            reason_reg <= gm3_pkg::STOP_LIMIT;
            prev_reg   <= '0;
        end else if (cmd.stop_wsum) begin
            reason_reg <= gm3_pkg::STOP_WSUM;
        end else if (cmd.iter_done) begin
            it_reg   <= it_reg + IT_W'(1);
            prev_reg <= cost_reg;
            if (stat.converged) begin
                reason_reg <= gm3_pkg::STOP_CONV;
            end
        end
    end

    // output register
    logic                          out_valid_reg;
    logic [gm3_pkg::OUT_W-1:0]     out_data_reg;
    logic [gm3_pkg::REASON_W-1:0]  out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {it_reg, est_reg[2], est_reg[1], est_reg[0]};
            out_user_reg <= reason_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        stat.sq_done    = sq_done_reg;
        stat.div_done   = div_done;
        stat.ax_last    = ax_reg == 2'd2;
        stat.idx_last   = CNT_W'(idx_reg + CNT_W'(1)) == cnt_reg;
        stat.iter_limit = it_reg == max_iter_reg;
        stat.pt_skip    = (dist_val == '0) || (dist_val < DIST_W'(zthr_reg));
        stat.wsum_low   = (wsum_reg == '0) ||
                          (wsum_reg < WS_W'({zthr_reg, gm3_pkg::THR_SHIFT'(0)}));
        stat.converged  = (it_reg != '0) && (cost_diff < COST_W'(eps_reg));
        stat.out_free   = !out_valid_reg || m_tready;
    end

endmodule

// ----- design/gm3_ctrl.sv -----
// Controller state machine sequencing loading, mean, Weiszfeld passes and output.
// Depends on gm3_pkg for the state, command and status types.
module gm3_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tlast,
    output logic           s_tready,
    input  gm3_pkg::stat_t stat,
    output gm3_pkg::cmd_t  cmd
);

    gm3_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gm3_pkg::S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = gm3_pkg::DIV_MEAN;
        cmd.mul_sel = gm3_pkg::MUL_SQ;
        s_tready    = 1'b0;

        case (state_reg)
            gm3_pkg::S_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_take = 1'b1;
                    if (s_tlast) begin
                        cmd.solve_init = 1'b1;
                        cmd.ax_clr     = 1'b1;
                        state_next     = gm3_pkg::S_MEAN_START;
                    end
                end
            end
            gm3_pkg::S_MEAN_START: begin
                cmd.div_start = 1'b1;
                state_next    = gm3_pkg::S_MEAN_WAIT;
            end
            gm3_pkg::S_MEAN_WAIT: begin
                if (stat.div_done) begin
                    cmd.est_load = 1'b1;
                    if (stat.ax_last) begin
                        state_next = gm3_pkg::S_ITER_CHECK;
                    end else begin
                        cmd.ax_inc = 1'b1;
                        state_next = gm3_pkg::S_MEAN_START;
                    end
                end
            end
            gm3_pkg::S_ITER_CHECK: begin
                if (stat.iter_limit) begin
                    state_next = gm3_pkg::S_FINISH;
                end else begin
                    cmd.pass_init = 1'b1;
                    state_next    = gm3_pkg::S_PT_READ;
                end
            end
            gm3_pkg::S_PT_READ: begin
                state_next = gm3_pkg::S_PT_LATCH;
            end
            gm3_pkg::S_PT_LATCH: begin
                cmd.pt_latch = 1'b1;
                cmd.ax_clr   = 1'b1;
                state_next   = gm3_pkg::S_SQ_MUL;
            end
            gm3_pkg::S_SQ_MUL: begin
                state_next = gm3_pkg::S_SQ_ACC;
            end
            gm3_pkg::S_SQ_ACC: begin
                cmd.q_acc = 1'b1;
                if (stat.ax_last) begin
                    state_next = gm3_pkg::S_SQRT_START;
                end else begin
                    cmd.ax_inc = 1'b1;
                    state_next = gm3_pkg::S_SQ_MUL;
                end
            end
            gm3_pkg::S_SQRT_START: begin
                cmd.sq_start = 1'b1;
                state_next   = gm3_pkg::S_SQRT_WAIT;
            end
            gm3_pkg::S_SQRT_WAIT: begin
                if (stat.sq_done) begin
                    state_next = gm3_pkg::S_PT_CHECK;
                end
            end
            gm3_pkg::S_PT_CHECK: begin
                cmd.div_sel = gm3_pkg::DIV_WEIGHT;
                if (stat.pt_skip) begin
                    state_next = gm3_pkg::S_NEXT_PT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = gm3_pkg::S_W_WAIT;
                end
            end
            gm3_pkg::S_W_WAIT: begin
                cmd.div_sel = gm3_pkg::DIV_WEIGHT;
                if (stat.div_done) begin
                    cmd.w_load = 1'b1;
                    cmd.ax_clr = 1'b1;
                    state_next = gm3_pkg::S_PW_LO;
                end
            end
            gm3_pkg::S_PW_LO: begin
                cmd.mul_sel = gm3_pkg::MUL_WLO;
                state_next  = gm3_pkg::S_PW_MID;
            end
            gm3_pkg::S_PW_MID: begin
                cmd.acc_lo  = 1'b1;
                cmd.mul_sel = gm3_pkg::MUL_WHI;
                state_next  = gm3_pkg::S_PW_HI;
            end
            gm3_pkg::S_PW_HI: begin
                cmd.acc_hi = 1'b1;
                if (stat.ax_last) begin
                    state_next = gm3_pkg::S_NEXT_PT;
                end else begin
                    cmd.ax_inc = 1'b1;
                    state_next = gm3_pkg::S_PW_LO;
                end
            end
            gm3_pkg::S_NEXT_PT: begin
                if (stat.idx_last) begin
                    state_next = gm3_pkg::S_PASS_END;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = gm3_pkg::S_PT_READ;
                end
            end
            gm3_pkg::S_PASS_END: begin
                // keep the estimate when the weights vanish
                if (stat.wsum_low) begin
                    cmd.stop_wsum = 1'b1;
                    state_next    = gm3_pkg::S_FINISH;
                end else begin
                    cmd.ax_clr = 1'b1;
                    state_next = gm3_pkg::S_EST_START;
                end
            end
            gm3_pkg::S_EST_START: begin
                cmd.div_sel   = gm3_pkg::DIV_EST;
                cmd.div_start = 1'b1;
                state_next    = gm3_pkg::S_EST_WAIT;
            end
            gm3_pkg::S_EST_WAIT: begin
                cmd.div_sel = gm3_pkg::DIV_EST;
                if (stat.div_done) begin
                    cmd.est_load = 1'b1;
                    if (stat.ax_last) begin
                        state_next = gm3_pkg::S_ITER_END;
                    end else begin
                        cmd.ax_inc = 1'b1;
                        state_next = gm3_pkg::S_EST_START;
                    end
                end
            end
            gm3_pkg::S_ITER_END: begin
                cmd.iter_done = 1'b1;
                if (stat.converged) begin
                    state_next = gm3_pkg::S_FINISH;
                end else begin
                    state_next = gm3_pkg::S_ITER_CHECK;
                end
            end
            gm3_pkg::S_FINISH: begin
                // hold until the output register can take the result
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.set_clear = 1'b1;
                    state_next    = gm3_pkg::S_LOAD;
                end
            end
            default: begin
                state_next = gm3_pkg::S_LOAD;
            end
        endcase
    end

endmodule

// ----- design/geometric_median_3d.sv -----
// Geometric median of a 3D point set by Weiszfeld iteration, top level.
// Depends on gm3_pkg, gm3_ctrl, gm3_dpath (with gm3_ram and gm3_div below it).
//
// Usage: points stream in on the s_ channel, one transfer per cycle while s_tready
// is high, x/y/z in signed Q16.16; s_tlast marks the final point of a set. Up to
// 1024 points are kept per set, later ones are dropped. After the last point the
// block starts at the mean (three 32-step divisions) and runs Weiszfeld passes over
// the stored points, then sends one result on the m_ channel: median x/y/z,
// passes done, and the stop reason in m_tuser.
// Each pass squares the distance of every stored point on the one shared
// multiplier and takes its square root at one bit per cycle; a point that
// contributes then runs the 44-step weight division and the weighted sums, a
// skipped point does not, and three 32-step divisions give the new estimate.
// s_tready is low from the last point until the result enters the output register.
// The output register lets the next set load while a result waits; if the
// receiver stalls, the following result waits in the controller until taken.
// Reset clears the set buffer and restores register defaults; no clearing pass.
// Configuration writes on cfg_ are always accepted (cfg_ready high).
module geometric_median_3d (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gm3_pkg::PT_W-1:0]           s_tdata,   // point_x, point_y, point_z
    input  logic                               s_tlast,   // last_point
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gm3_pkg::OUT_W-1:0]          m_tdata,   // median_x, median_y, median_z,
                                                          // iterations_done
    output logic [gm3_pkg::REASON_W-1:0]       m_tuser,   // stop_reason
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gm3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gm3_pkg::CFG_DATA_W-1:0]     cfg_data
);

    gm3_pkg::cmd_t  cmd;
    gm3_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    gm3_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gm3_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
